// ===== rtl/sqd_pkg.sv =====
// shared types, constants and state encoding for the shortest queue dispatcher
package sqd_pkg;

  localparam int NUM_QUEUES_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_SERVICE_DEF = 10;

  localparam logic [3:0] ACTIVE_QUEUES_RESET = 4'd8;

  typedef struct packed {
    logic       arrival_valid;
    logic [3:0] service_time;
  } in_t;

  typedef struct packed {
    logic [2:0] assigned_queue;
    logic       arrival_dropped;
    logic [7:0] finished_mask;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ARRIVE,
    ST_SERVE,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/shortest_queue_dispatcher_core.sv =====
// top level of the join shortest queue dispatcher
// One input transfer is one time tick and yields one result transfer. A tick walks the
// queue descriptor ram one queue per cycle: with an arrival it first scans the n active
// queue lengths, inserts the job, then services every active queue head; without an
// arrival the scan is skipped, n being the number of active queues. A new tick is
// accepted while the previous result still waits in the output register. Descriptor
// valid bits clear at reset, so no clearing pass is needed; the job ram needs none
// either.
module shortest_queue_dispatcher_core #(
  parameter int NUM_QUEUES  = sqd_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = sqd_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_SERVICE = sqd_pkg::MAX_SERVICE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_stall,
  input  sqd_pkg::in_t  item,
  output logic          result_valid,
  input  logic          result_stall,
  output sqd_pkg::out_t result,
  input  logic          cfg_wr_en,
  input  logic [3:0]    cfg_wr_data
);

  localparam int QW = $clog2(NUM_QUEUES);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam int RW = $clog2(MAX_SERVICE + 1);
  localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int DW = LW + 2 * PW;

  logic          desc_we;
  logic [QW-1:0] desc_waddr;
  logic [DW-1:0] desc_wdata;
  logic [QW-1:0] desc_raddr;
  logic [DW-1:0] desc_rdata;
  logic          job_we;
  logic [AW-1:0] job_waddr;
  logic [RW-1:0] job_wdata;
  logic [AW-1:0] job_raddr;
  logic [RW-1:0] job_rdata;

  sqd_ctrl #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_SERVICE (MAX_SERVICE)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .desc_we      (desc_we),
    .desc_waddr   (desc_waddr),
    .desc_wdata   (desc_wdata),
    .desc_raddr   (desc_raddr),
    .desc_rdata   (desc_rdata),
    .job_we       (job_we),
    .job_waddr    (job_waddr),
    .job_wdata    (job_wdata),
    .job_raddr    (job_raddr),
    .job_rdata    (job_rdata)
  );

  sqd_desc_ram #(
    .WIDTH (DW),
    .DEPTH (NUM_QUEUES)
  ) u_desc_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (desc_we),
    .waddr (desc_waddr),
    .wdata (desc_wdata),
    .raddr (desc_raddr),
    .rdata (desc_rdata)
  );

  sqd_ram #(
    .WIDTH (RW),
    .DEPTH (NUM_QUEUES * QUEUE_DEPTH)
  ) u_job_ram (
    .clk   (clk),
    .we    (job_we),
    .waddr (job_waddr),
    .wdata (job_wdata),
    .raddr (job_raddr),
    .rdata (job_rdata)
  );

endmodule

// ===== rtl/sqd_ram.sv =====
// simple dual port ram, one write and one registered read per cycle
module sqd_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sqd_desc_ram.sv =====
// queue descriptor ram with per entry valid bits, unwritten entries read as zero
module sqd_desc_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [WIDTH-1:0] rd_word;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_word <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rd_vld <= vld[raddr];
    end
  end

  assign rdata = rd_vld ? rd_word : '0;

endmodule

// ===== rtl/sqd_ctrl.sv =====
// tick sequencer: shortest queue scan, job insert and head service over the two rams
module sqd_ctrl #(
  parameter int NUM_QUEUES  = sqd_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = sqd_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_SERVICE = sqd_pkg::MAX_SERVICE_DEF,
  localparam int QW = $clog2(NUM_QUEUES),
  localparam int PW = $clog2(QUEUE_DEPTH),
  localparam int LW = $clog2(QUEUE_DEPTH + 1),
  localparam int RW = $clog2(MAX_SERVICE + 1),
  localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH),
  localparam int DW = LW + 2 * PW
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  sqd_pkg::in_t       item,
  output logic               result_valid,
  input  logic               result_stall,
  output sqd_pkg::out_t      result,
  input  logic               cfg_wr_en,
  input  logic [3:0]         cfg_wr_data,
  output logic               desc_we,
  output logic [QW-1:0]      desc_waddr,
  output logic [DW-1:0]      desc_wdata,
  output logic [QW-1:0]      desc_raddr,
  input  logic [DW-1:0]      desc_rdata,
  output logic               job_we,
  output logic [AW-1:0]      job_waddr,
  output logic [RW-1:0]      job_wdata,
  output logic [AW-1:0]      job_raddr,
  input  logic [RW-1:0]      job_rdata
);

  localparam int CW = $clog2(NUM_QUEUES + 1);

  sqd_pkg::state_t state, state_next;

  logic [3:0]            active_queues;
  logic [CW-1:0]         live;
  logic [CW-1:0]         live_calc;
  logic [CW-1:0]         idx;
  logic                  arrival;
  logic [RW-1:0]         svc;
  logic [RW-1:0]         svc_calc;
  logic [QW-1:0]         best_q;
  logic [LW-1:0]         best_len;
  logic [PW-1:0]         best_head;
  logic [PW-1:0]         best_tail;
  logic                  dropped;
  logic [NUM_QUEUES-1:0] fin;
  logic                  s1_vld;
  logic [QW-1:0]         s1_q;
  logic                  s2_vld;
  logic [QW-1:0]         s2_q;
  logic [LW-1:0]         s2_len;
  logic [PW-1:0]         s2_head;
  logic [PW-1:0]         s2_tail;
  logic [LW-1:0]         rd_len;
  logic [PW-1:0]         rd_head;
  logic [PW-1:0]         rd_tail;
  logic [RW-1:0]         r_next;
  logic                  full;
  logic                  issue;
  logic                  take_item;
  logic                  load_result;
  logic                  s2_load;
  logic [31:0]           act32;
  logic [31:0]           st32;

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [AW-1:0] job_addr(input logic [QW-1:0] q,
                                             input logic [PW-1:0] p);
    job_addr = AW'(int'(q) * QUEUE_DEPTH + int'(p));
  endfunction

  assign rd_len  = desc_rdata[DW-1 -: LW];
  assign rd_head = desc_rdata[2*PW-1 -: PW];
  assign rd_tail = desc_rdata[PW-1:0];
  assign r_next  = (job_rdata > RW'(1)) ? job_rdata - RW'(1) : '0;
  assign full    = (best_len == LW'(QUEUE_DEPTH));

  // clamp register and service time into range
  always_comb begin
    act32 = 32'(active_queues);
    st32  = 32'(item.service_time);
    if (act32 == 32'd0) begin
      live_calc = CW'(1);
    end else if (act32 > 32'(NUM_QUEUES)) begin
      live_calc = CW'(NUM_QUEUES);
    end else begin
      live_calc = CW'(act32);
    end
    if (st32 == 32'd0) begin
      svc_calc = RW'(1);
    end else if (st32 > 32'(MAX_SERVICE)) begin
      svc_calc = RW'(MAX_SERVICE);
    end else begin
      svc_calc = RW'(st32);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sqd_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = item.arrival_valid ? sqd_pkg::ST_SCAN : sqd_pkg::ST_SERVE;
        end
      end
      sqd_pkg::ST_SCAN: begin
        if (idx == live && !s1_vld) begin
          state_next = sqd_pkg::ST_ARRIVE;
        end
      end
      sqd_pkg::ST_ARRIVE: begin
        state_next = sqd_pkg::ST_SERVE;
      end
      sqd_pkg::ST_SERVE: begin
        if (idx == live && !s1_vld && !s2_vld) begin
          state_next = sqd_pkg::ST_DONE;
        end
      end
      sqd_pkg::ST_DONE: begin
        if (!result_valid || !result_stall) begin
          state_next = sqd_pkg::ST_IDLE;
        end
      end
      default: state_next = sqd_pkg::ST_IDLE;
    endcase
  end

  // control outputs and ram ports
  always_comb begin
    item_stall  = 1'b1;
    take_item   = 1'b0;
    issue       = 1'b0;
    load_result = 1'b0;
    s2_load     = 1'b0;
    desc_we     = 1'b0;
    desc_waddr  = s2_q;
    desc_wdata  = {s2_len - LW'(1), ring_next(s2_head), s2_tail};
    desc_raddr  = idx[QW-1:0];
    job_we      = 1'b0;
    job_waddr   = job_addr(s2_q, s2_head);
    job_wdata   = r_next;
    job_raddr   = job_addr(s1_q, rd_head);
    case (state)
      sqd_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        take_item  = item_valid;
      end
      sqd_pkg::ST_SCAN: begin
        issue = (idx < live);
      end
      sqd_pkg::ST_ARRIVE: begin
        if (!full) begin
          desc_we    = 1'b1;
          desc_waddr = best_q;
          desc_wdata = {best_len + LW'(1), best_head, ring_next(best_tail)};
          job_we     = 1'b1;
          job_waddr  = job_addr(best_q, best_tail);
          job_wdata  = svc;
        end
      end
      sqd_pkg::ST_SERVE: begin
        issue   = (idx < live);
        s2_load = s1_vld && (rd_len != '0);
        if (s2_vld) begin
          job_we  = 1'b1;
          desc_we = (r_next == '0);
        end
      end
      sqd_pkg::ST_DONE: begin
        load_result = !result_valid || !result_stall;
      end
      default: item_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= sqd_pkg::ST_IDLE;
      active_queues <= sqd_pkg::ACTIVE_QUEUES_RESET;
      result_valid  <= 1'b0;
      s1_vld        <= 1'b0;
      s2_vld        <= 1'b0;
    end else begin
      state  <= state_next;
      s1_vld <= issue;
      s2_vld <= s2_load;
      if (cfg_wr_en) begin
        active_queues <= cfg_wr_data;
      end
      if (load_result) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_item) begin
      live    <= live_calc;
      arrival <= item.arrival_valid;
      svc     <= svc_calc;
      best_q  <= '0;
      dropped <= 1'b0;
      fin     <= '0;
      idx     <= '0;
    end
    if (issue) begin
      idx <= idx + CW'(1);
    end
    if (state == sqd_pkg::ST_ARRIVE) begin
      idx     <= '0;
      dropped <= full;
    end
    // lowest index wins a tie
    if (state == sqd_pkg::ST_SCAN && s1_vld && (s1_q == '0 || rd_len < best_len)) begin
      best_q    <= s1_q;
      best_len  <= rd_len;
      best_head <= rd_head;
      best_tail <= rd_tail;
    end
    s1_q    <= idx[QW-1:0];
    s2_q    <= s1_q;
    s2_len  <= rd_len;
    s2_head <= rd_head;
    s2_tail <= rd_tail;
    if (s2_vld && r_next == '0) begin
      fin[s2_q] <= 1'b1;
    end
    if (load_result) begin
      result.assigned_queue  <= arrival ? 3'(best_q) : 3'd0;
      result.arrival_dropped <= arrival & dropped;
      result.finished_mask   <= 8'(fin);
    end
  end

`ifndef ASSERT_OFF
  a_desc_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (desc_we && issue) |-> (desc_waddr != desc_raddr))
    else $error("descriptor read and write hit the same queue");

  a_scan_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == sqd_pkg::ST_SCAN) |-> (!desc_we && !job_we))
    else $error("ram write during length scan");

  a_fin_live: assert property (@(posedge clk) disable iff (rst)
    (state == sqd_pkg::ST_DONE) |-> ((fin >> live) == '0))
    else $error("inactive queue marked finished");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == sqd_pkg::ST_DONE))
    else $error("result loaded outside done state");

  a_stage_order: assert property (@(posedge clk) disable iff (rst)
    s2_vld |-> $past(s1_vld))
    else $error("service stage two without stage one");
`endif

endmodule

// ===== tb/sv/tb_shortest_queue_dispatcher_core.sv =====
// testbench for the shortest queue dispatcher: directed and random ticks against a predictor
`timescale 1ns / 1ps

module tb_shortest_queue_dispatcher_core;

  localparam int NQ       = sqd_pkg::NUM_QUEUES_DEF;
  localparam int DEPTH    = sqd_pkg::QUEUE_DEPTH_DEF;
  localparam int MAX_SVC  = sqd_pkg::MAX_SERVICE_DEF;
  localparam int STALL_PCT = 22;
  localparam int STUCK_LIMIT = 4000;
  localparam int PHASE_TICKS = 45;
  localparam int PEND_MAX = 1024;

  logic          clk;
  logic          rst;
  logic          item_valid = 1'b0;
  logic          item_stall;
  sqd_pkg::in_t  item = '0;
  logic          result_valid;
  logic          result_stall = 1'b0;
  sqd_pkg::out_t result;
  logic          cfg_wr_en;
  logic [3:0]    cfg_wr_data;

  shortest_queue_dispatcher_core dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // predictor state
  logic [3:0] job_left [NQ][DEPTH];
  logic [4:0] q_len [NQ];
  logic [3:0] q_head [NQ];
  logic [3:0] q_tail [NQ];
  logic [3:0] live_cfg;

  sqd_pkg::in_t  pend_ticks [PEND_MAX];
  logic [9:0]    pend_wr = '0;
  logic [9:0]    pend_rd = '0;
  sqd_pkg::out_t exp_dispatch [PEND_MAX];
  logic [9:0]    exp_wr = '0;
  logic [9:0]    exp_rd = '0;
  int   ticks_outstanding = 0;
  bit   tick_taken = 1'b0;
  bit   gaps_on = 1'b1;
  int   mismatches = 0;
  int   stuck_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [3:0] ring_next(input logic [3:0] p);
    return (p == DEPTH - 1) ? 4'd0 : p + 4'd1;
  endfunction

  function automatic sqd_pkg::out_t dispatch_tick(input sqd_pkg::in_t t);
    sqd_pkg::out_t r;
    int n;
    int best;
    logic [3:0] svc;
    r = '0;
    n = (live_cfg == 0) ? 1 : (live_cfg > NQ) ? NQ : live_cfg;
    if (t.arrival_valid) begin
      svc = (t.service_time == 0) ? 4'd1 :
            (t.service_time > MAX_SVC) ? 4'(MAX_SVC) : t.service_time;
      best = 0;
      for (int i = 1; i < n; i++)
        if (q_len[i] < q_len[best]) best = i;
      r.assigned_queue = best[2:0];
      if (q_len[best] >= DEPTH) begin
        r.arrival_dropped = 1'b1;
      end else begin
        job_left[best][q_tail[best]] = svc;
        q_tail[best] = ring_next(q_tail[best]);
        q_len[best]++;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (q_len[i] != 0) begin
        if (job_left[i][q_head[i]] > 1) job_left[i][q_head[i]]--;
        else job_left[i][q_head[i]] = 4'd0;
        if (job_left[i][q_head[i]] == 0) begin
          q_head[i] = ring_next(q_head[i]);
          q_len[i]--;
          r.finished_mask[i] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // input side: present the next tick at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!item_valid || tick_taken) begin
      tick_taken = 1'b0;
      if (pend_rd != pend_wr && !(gaps_on && $urandom_range(0, 99) < STALL_PCT)) begin
        item <= pend_ticks[pend_rd];
        pend_rd = pend_rd + 10'd1;
        item_valid <= 1'b1;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // output side backpressure
  always @(negedge clk) begin
    result_stall <= !rst && gaps_on && ($urandom_range(0, 99) < STALL_PCT);
  end

  // transfer monitor, checker and watchdog
  always @(posedge clk) begin
    if (rst) begin
      stuck_cycles <= 0;
    end else begin
      if (item_valid && !item_stall) begin
        exp_dispatch[exp_wr] = dispatch_tick(item);
        exp_wr = exp_wr + 10'd1;
        ticks_outstanding--;
        tick_taken = 1'b1;
      end
      if (result_valid && !result_stall) begin
        if (exp_rd == exp_wr) begin
          $error("unexpected result transfer: %p", result);
          mismatches++;
        end else begin
          sqd_pkg::out_t want;
          want = exp_dispatch[exp_rd];
          exp_rd = exp_rd + 10'd1;
          if (result.assigned_queue !== want.assigned_queue) begin
            $error("assigned_queue: expected %0d, got %0d",
                   want.assigned_queue, result.assigned_queue);
            mismatches++;
          end
          if (result.arrival_dropped !== want.arrival_dropped) begin
            $error("arrival_dropped: expected %0d, got %0d",
                   want.arrival_dropped, result.arrival_dropped);
            mismatches++;
          end
          if (result.finished_mask !== want.finished_mask) begin
            $error("finished_mask: expected %02h, got %02h",
                   want.finished_mask, result.finished_mask);
            mismatches++;
          end
        end
      end
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
        $display("tb_shortest_queue_dispatcher_core: done, errors");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  task automatic queue_tick(input logic arrive, input logic [3:0] svc);
    sqd_pkg::in_t t;
    t.arrival_valid = arrive;
    t.service_time = svc;
    pend_ticks[pend_wr] = t;
    pend_wr = pend_wr + 10'd1;
    ticks_outstanding++;
  endtask

  task automatic wait_drained();
    while (ticks_outstanding != 0 || exp_rd != exp_wr) @(negedge clk);
  endtask

  task automatic write_active(input logic [3:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    live_cfg = v;
  endtask

  task automatic random_ticks(input int count, input int arrive_pct, input bit heavy);
    for (int k = 0; k < count; k++)
      queue_tick($urandom_range(0, 99) < arrive_pct,
                 heavy ? 4'($urandom_range(4, 15)) : 4'($urandom_range(0, 15)));
  endtask

  initial begin
    logic [3:0] phase_cfg [10];
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 4'd0;
    for (int i = 0; i < NQ; i++) begin
      q_len[i] = '0;
      q_head[i] = '0;
      q_tail[i] = '0;
      for (int j = 0; j < DEPTH; j++) job_left[i][j] = '0;
    end
    live_cfg = sqd_pkg::ACTIVE_QUEUES_RESET;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset setting: service clamps and ticks without arrival
    queue_tick(1'b1, 4'd0);
    queue_tick(1'b1, 4'd15);
    queue_tick(1'b1, 4'd10);
    queue_tick(1'b1, 4'd1);
    queue_tick(1'b0, 4'd15);
    queue_tick(1'b0, 4'd0);
    wait_drained();

    // zero acts as one queue: fill it until arrivals drop
    write_active(4'd0);
    for (int k = 0; k < 19; k++) queue_tick(1'b1, 4'd15);
    wait_drained();

    phase_cfg = '{4'd15, 4'd1, 4'd2, 4'd8, 4'd3, 4'd0, 4'd5, 4'd1, 4'd7, 4'd15};
    for (int p = 0; p < 10; p++) begin
      write_active((p >= 4 && p % 3 == 1) ? 4'($urandom_range(0, 15)) : phase_cfg[p]);
      gaps_on = (p != 3);
      if (p == 6) begin
        random_ticks(PHASE_TICKS / 2, 70, 1'b1);
        wait_drained();
        random_ticks(PHASE_TICKS - PHASE_TICKS / 2, 70, 1'b1);
      end else begin
        random_ticks(PHASE_TICKS, (p % 2) ? 90 : 40, bit'(p % 2));
      end
      wait_drained();
    end
    gaps_on = 1'b1;

    repeat (60) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_shortest_queue_dispatcher_core: done, clean");
    end else begin
      $display("tb_shortest_queue_dispatcher_core: done, errors");
    end
    $finish;
  end

endmodule
